[rtl/arpb_pkg.sv]
package arpb_pkg;

  // address and count widths
  localparam int ADDR_BITS = 32;
  localparam int CNT_W     = ADDR_BITS + 1;
  localparam int LEN_W     = 6;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ASCEND,
    ST_DESCEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_asc;
    logic to_desc;
    logic scan;
    logic emit_desc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rem_zero;
    logic fits;
    logic last_asc;
    logic hit;
    logic last_desc;
  } status_t;

  // bit position of a one-hot word, built as an or of indexes
  function automatic logic [LEN_W-1:0] onehot_index(input logic [CNT_W-1:0] oh);
    logic [LEN_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (oh[i]) begin
        idx = idx | LEN_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

[rtl/arpb_ctrl.sv]
module arpb_ctrl
  import arpb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output cmd_t    cmd,
  output logic    busy
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_ASCEND;
      end
      ST_ASCEND: begin
        if (status.rem_zero) begin
          state_next = ST_IDLE;
        end else if (status.fits) begin
          if (status.last_asc) state_next = ST_IDLE;
        end else begin
          state_next = ST_DESCEND;
        end
      end
      ST_DESCEND: begin
        if (status.rem_zero || (status.hit && status.last_desc)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_ASCEND: begin
        if (!status.rem_zero) begin
          cmd.emit_asc = status.fits;
          cmd.to_desc  = !status.fits;
        end
      end
      ST_DESCEND: begin
        cmd.scan      = 1'b1;
        cmd.emit_desc = status.hit;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

[rtl/arpb_datapath.sv]
module arpb_datapath
  import arpb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  input  logic [ADDR_BITS-1:0] start_address,
  input  logic [CNT_W-1:0]     address_count,
  output status_t              status,
  output logic [ADDR_BITS-1:0] block_base,
  output logic [LEN_W-1:0]     prefix_length,
  output logic                 last_block,
  output logic                 result_valid
);

  localparam logic [CNT_W-1:0] SPACE = {1'b1, {ADDR_BITS{1'b0}}};

  logic [ADDR_BITS-1:0] cur;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     probe;
  logic [LEN_W-1:0]     plen;

  logic [CNT_W-1:0]     room;
  logic [CNT_W-1:0]     rem_load;
  logic [ADDR_BITS-1:0] low_bit;
  logic [CNT_W-1:0]     lsize;
  logic [LEN_W-1:0]     asc_len;

  // clamp the range at the top of the address space
  assign room     = SPACE - {1'b0, start_address};
  assign rem_load = (address_count > room) ? room : address_count;

  // largest block aligned at the current address
  assign low_bit = cur & (~cur + ADDR_BITS'(1));
  assign lsize   = (cur == '0) ? SPACE : {1'b0, low_bit};
  assign asc_len = LEN_W'(ADDR_BITS) - onehot_index(lsize);

  // status toward the controller
  assign status.rem_zero  = (rem == '0);
  assign status.fits      = (lsize <= rem);
  assign status.last_asc  = (rem == lsize);
  assign status.hit       = ((rem & probe) != '0);
  assign status.last_desc = (rem == probe);

  // walk state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= start_address;
      rem <= rem_load;
    end else if (cmd.emit_asc) begin
      cur <= cur + lsize[ADDR_BITS-1:0];
      rem <= rem - lsize;
    end else if (cmd.emit_desc) begin
      cur <= cur + probe[ADDR_BITS-1:0];
      rem <= rem - probe;
    end
  end

  // probe walks down the remaining count one bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.to_desc) begin
      probe <= lsize >> 1;
      plen  <= asc_len + LEN_W'(1);
    end else if (cmd.scan) begin
      probe <= probe >> 1;
      plen  <= plen + LEN_W'(1);
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (cmd.emit_asc) begin
      block_base    <= cur;
      prefix_length <= asc_len;
      last_block    <= status.last_asc;
    end else if (cmd.emit_desc) begin
      block_base    <= cur;
      prefix_length <= plen;
      last_block    <= status.last_desc;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit_asc || cmd.emit_desc;
    end
  end

endmodule

[rtl/address_range_to_prefix_blocks_top.sv]
// the first block beat follows start through the walk registers and the result beat
// register, then one block beat per cycle while block sizes grow, then a turn step
// that emits nothing, then the probe walks down the remaining count while sizes shrink
// throughput: one range at a time, next start taken in the cycle the last beat shows
// reset: synchronous rst returns the sequencer to idle and drops the result strobe
// result beats cannot be stalled by the receiver
module address_range_to_prefix_blocks_top
  import arpb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] start_address,
  input  logic [CNT_W-1:0]     address_count,
  output logic                 result_valid,
  output logic [ADDR_BITS-1:0] block_base,
  output logic [LEN_W-1:0]     prefix_length,
  output logic                 last_block
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  arpb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // address walk and result registers
  arpb_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .start_address (start_address),
    .address_count (address_count),
    .status        (status),
    .block_base    (block_base),
    .prefix_length (prefix_length),
    .last_block    (last_block),
    .result_valid  (result_valid)
  );

  // an accepted range always starts the walk
  a_start_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted range did not raise busy");

  // the final block beat leaves the sequencer idle
  a_last_idle : assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_block) |-> !busy)
    else $error("busy still high on final block beat");

  // prefix length stays within the address width
  a_len_range : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (prefix_length <= LEN_W'(ADDR_BITS)))
    else $error("prefix length out of range");

  // every emitted block is aligned to its own size
  a_aligned : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (({1'b0, block_base} &
      ((CNT_W'(1) << (LEN_W'(ADDR_BITS) - prefix_length)) - CNT_W'(1))) == '0))
    else $error("block base not aligned to block size");

endmodule
